### rtl/r2h_pkg.sv
// Shared types and widths for the RGB to HSV converter.
// Used by the front stage, the divider cells and the top level.
package r2h_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  // Six times delta needs three bits more than a channel.
  localparam int HUE_REM_BITS  = CHANNEL_BITS + 3;
  // Signed hue numerator before the wrap into one turn.
  localparam int NUM_BITS      = CHANNEL_BITS + 4;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue_turn;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0]  brightness;
  } hsv_t;

  // Work in flight through the chain of divider cells.
  typedef struct packed {
    logic                     valid;
    logic                     hue_zero;
    logic                     sat_zero;
    logic [CHANNEL_BITS-1:0]  bright;
    logic [CHANNEL_BITS-1:0]  sat_div;
    logic [CHANNEL_BITS-1:0]  sat_rem;
    logic [FRACTION_BITS-1:0] sat_low;
    logic [FRACTION_BITS-1:0] sat_quo;
    logic [HUE_REM_BITS-1:0]  hue_div;
    logic [HUE_REM_BITS-1:0]  hue_rem;
    logic [FRACTION_BITS-1:0] hue_quo;
  } stage_t;

endpackage

### rtl/r2h_front.sv
// Front end of the converter: max, min, delta, hue numerator and the
// initial remainders for both divisions. Depends on r2h_pkg.
module r2h_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  r2h_pkg::pix_t   in_pixel,
  output r2h_pkg::stage_t stage_o
);

  localparam int CB = r2h_pkg::CHANNEL_BITS;
  localparam int FB = r2h_pkg::FRACTION_BITS;
  localparam int HR = r2h_pkg::HUE_REM_BITS;
  localparam int NB = r2h_pkg::NUM_BITS;

  // First step: find the largest and smallest channel.
  logic                a_valid_r;
  r2h_pkg::pix_t       a_pix_r;
  logic [CB-1:0]       a_mx_r, a_mn_r;
  logic [CB-1:0]       mx_nxt, mn_nxt, rg_max, rg_min;

  always_comb begin
    rg_max = (in_pixel.red > in_pixel.green) ? in_pixel.red : in_pixel.green;
    rg_min = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
    mx_nxt = (rg_max > in_pixel.blue) ? rg_max : in_pixel.blue;
    mn_nxt = (rg_min < in_pixel.blue) ? rg_min : in_pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    a_pix_r <= in_pixel;
    a_mx_r  <= mx_nxt;
    a_mn_r  <= mn_nxt;
  end

  // Second step: delta, the wrapped hue numerator and the saturation dividend.
  logic [CB-1:0]        delta;
  logic [HR-1:0]        delta_ext, six_delta;
  logic signed [NB-1:0] r_s, g_s, b_s, d_s, six_s, num, num_wrap;
  logic [CB+FB-1:0]     sat_dividend;
  r2h_pkg::stage_t      stage_nxt, stage_r;

  always_comb begin
    delta     = a_mx_r - a_mn_r;
    delta_ext = {{(HR-CB){1'b0}}, delta};
    six_delta = (delta_ext << 2) + (delta_ext << 1);
    r_s   = $signed({{(NB-CB){1'b0}}, a_pix_r.red});
    g_s   = $signed({{(NB-CB){1'b0}}, a_pix_r.green});
    b_s   = $signed({{(NB-CB){1'b0}}, a_pix_r.blue});
    d_s   = $signed({{(NB-CB){1'b0}}, delta});
    six_s = $signed({{(NB-HR){1'b0}}, six_delta});
    // Red wins ties, then green.
    if (a_pix_r.red == a_mx_r) begin
      num = g_s - b_s;
    end else if (a_pix_r.green == a_mx_r) begin
      num = (d_s <<< 1) + b_s - r_s;
    end else begin
      num = (d_s <<< 2) + r_s - g_s;
    end
    num_wrap = num[NB-1] ? (num + six_s) : num;
    // delta * (2^FB - 1), the top bits start the long division.
    sat_dividend = {delta, {FB{1'b0}}} - {{FB{1'b0}}, delta};

    stage_nxt          = '0;
    stage_nxt.valid    = a_valid_r;
    stage_nxt.hue_zero = (delta == '0);
    stage_nxt.sat_zero = (a_mx_r == '0);
    stage_nxt.bright   = a_mx_r;
    stage_nxt.sat_div  = a_mx_r;
    stage_nxt.sat_rem  = sat_dividend[CB+FB-1:FB];
    stage_nxt.sat_low  = sat_dividend[FB-1:0];
    stage_nxt.hue_div  = six_delta;
    stage_nxt.hue_rem  = num_wrap[HR-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### rtl/r2h_cell.sv
// One divider cell: a restoring step for saturation and for hue, giving
// one quotient bit of each per pixel. Depends on r2h_pkg.
module r2h_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  r2h_pkg::stage_t stage_i,
  output r2h_pkg::stage_t stage_o
);

  localparam int CB = r2h_pkg::CHANNEL_BITS;
  localparam int FB = r2h_pkg::FRACTION_BITS;
  localparam int HR = r2h_pkg::HUE_REM_BITS;

  logic [CB:0]     sat_trial, sat_diff;
  logic [HR:0]     hue_trial, hue_diff;
  logic            sat_ge, hue_ge;
  r2h_pkg::stage_t stage_nxt, stage_r;

  always_comb begin
    // Bring down the next dividend bit; the hue dividend's low bits are zero.
    sat_trial = {stage_i.sat_rem, stage_i.sat_low[FB-1]};
    sat_diff  = sat_trial - {1'b0, stage_i.sat_div};
    sat_ge    = (sat_trial >= {1'b0, stage_i.sat_div});
    hue_trial = {stage_i.hue_rem, 1'b0};
    hue_diff  = hue_trial - {1'b0, stage_i.hue_div};
    hue_ge    = (hue_trial >= {1'b0, stage_i.hue_div});

    stage_nxt         = stage_i;
    stage_nxt.sat_rem = sat_ge ? sat_diff[CB-1:0] : sat_trial[CB-1:0];
    stage_nxt.sat_low = {stage_i.sat_low[FB-2:0], 1'b0};
    stage_nxt.sat_quo = {stage_i.sat_quo[FB-2:0], sat_ge};
    stage_nxt.hue_rem = hue_ge ? hue_diff[HR-1:0] : hue_trial[HR-1:0];
    stage_nxt.hue_quo = {stage_i.hue_quo[FB-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

### rtl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter: two front stages, a chain of FRACTION_BITS divider
// cells (one quotient bit each) and an output register; 19 stages in all.
// Throughput: one pixel per clock; busy is never raised.
// A pixel passes the front, cell and output registers before out_valid rises.
// The result beat is shown for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears every valid bit; data is not reset.
module rgb_to_hsv_converter_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  r2h_pkg::pix_t in_pixel,
  output logic          out_valid,
  output r2h_pkg::hsv_t out_hsv
);

  localparam int FB      = r2h_pkg::FRACTION_BITS;
  localparam int LATENCY = FB + 3;

  r2h_pkg::stage_t chain [FB+1];
  logic            in_fire;
  logic            out_valid_r;
  r2h_pkg::hsv_t   out_hsv_r, out_hsv_nxt;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  r2h_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .in_pixel (in_pixel),
    .stage_o  (chain[0])
  );

  for (genvar i = 0; i < FB; i++) begin : g_cell
    r2h_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // Black pixels zero everything; gray pixels zero the hue.
  always_comb begin
    out_hsv_nxt.hue_turn   = chain[FB].hue_zero ? '0 : chain[FB].hue_quo;
    out_hsv_nxt.saturation = chain[FB].sat_zero ? '0 : chain[FB].sat_quo;
    out_hsv_nxt.brightness = chain[FB].bright;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[FB].valid;
    end
    out_hsv_r <= out_hsv_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hsv   = out_hsv_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("accepted pixel did not produce a result beat on time");

  a_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hsv.brightness == '0) |->
      (out_hsv.saturation == '0 && out_hsv.hue_turn == '0))
    else $error("black pixel gave nonzero hue or saturation");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, LATENCY)) |-> $past(in_fire, LATENCY))
    else $error("result beat without an accepted pixel");

endmodule

### tb/sv/rgb_to_hsv_checker.sv
// Result checker for the RGB to HSV converter: predicts each pixel's hue,
// saturation and brightness and compares them with the result beats.
// Depends on r2h_pkg for the pixel and result types.
module rgb_to_hsv_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  r2h_pkg::pix_t in_pixel,
  input  logic          out_valid,
  input  r2h_pkg::hsv_t out_hsv,
  output int            fail_count,
  output int            pending_hsv
);
  import r2h_pkg::*;

  hsv_t hsv_due[$];
  int   fail_count_r = 0;
  int   pending_r = 0;

  function automatic hsv_t predict_hsv(pix_t p);
    int   r;
    int   g;
    int   b;
    int   mx;
    int   mn;
    int   delta;
    int   num;
    hsv_t h;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    h = '0;
    h.brightness = CHANNEL_BITS'(mx);
    // Black gives all zeros; gray keeps hue at zero.
    if (mx != 0) begin
      h.saturation = FRACTION_BITS'((delta * ((1 << FRACTION_BITS) - 1)) / mx);
      if (delta != 0) begin
        if (r == mx) begin
          num = g - b;
        end else if (g == mx) begin
          num = 2 * delta + (b - r);
        end else begin
          num = 4 * delta + (r - g);
        end
        if (num < 0) num += 6 * delta;
        h.hue_turn = FRACTION_BITS'((longint'(num) << FRACTION_BITS) / (6 * delta));
      end
    end
    return h;
  endfunction

  assign fail_count  = fail_count_r;
  assign pending_hsv = pending_r;

  always @(posedge clk) begin
    hsv_t want;
    int   errs;
    errs = 0;
    if (rst_n) begin
      if (out_valid) begin
        if (hsv_due.size() == 0) begin
          $error("result beat with no pixel waiting: %p", out_hsv);
          errs++;
        end else begin
          want = hsv_due.pop_front();
          if (out_hsv.hue_turn !== want.hue_turn) begin
            $error("hue_turn: expected %0d, got %0d", want.hue_turn, out_hsv.hue_turn);
            errs++;
          end
          if (out_hsv.saturation !== want.saturation) begin
            $error("saturation: expected %0d, got %0d", want.saturation,
                   out_hsv.saturation);
            errs++;
          end
          if (out_hsv.brightness !== want.brightness) begin
            $error("brightness: expected %0d, got %0d", want.brightness,
                   out_hsv.brightness);
            errs++;
          end
        end
      end
      if (start && !busy) hsv_due.push_back(predict_hsv(in_pixel));
    end
    fail_count_r <= fail_count_r + errs;
    pending_r    <= hsv_due.size();
  end

endmodule

### tb/sv/rgb_to_hsv_converter_unit_tb.sv
// Top of the RGB to HSV converter testbench: clock, reset and pixel stimulus.
// Depends on r2h_pkg, rgb_to_hsv_converter_unit and rgb_to_hsv_checker.
module rgb_to_hsv_converter_unit_tb;
  import r2h_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pix_t in_pixel;
  logic out_valid;
  hsv_t out_hsv;
  int   fail_count;
  int   pending_hsv;

  rgb_to_hsv_converter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_hsv   (out_hsv)
  );

  rgb_to_hsv_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_pixel    (in_pixel),
    .out_valid   (out_valid),
    .out_hsv     (out_hsv),
    .fail_count  (fail_count),
    .pending_hsv (pending_hsv)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("rgb_to_hsv_converter_unit: mismatch");
    $finish;
  end

  function automatic logic [7:0] rand_level();
    case ($urandom_range(5))
      0: rand_level = 8'd0;
      1: rand_level = 8'd255;
      2: rand_level = 8'($urandom_range(3));
      3: rand_level = 8'($urandom_range(255, 252));
      default: rand_level = 8'($urandom);
    endcase
  endfunction

  // Mostly random pixels, with grays and tied maxima mixed in.
  function automatic pix_t rand_pixel();
    pix_t p;
    p.red   = rand_level();
    p.green = rand_level();
    p.blue  = rand_level();
    case ($urandom_range(9))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: p.green = p.red;
      2: p.blue = p.green;
      3: p.blue = p.red;
      default: ;
    endcase
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_pixel(input pix_t p, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    pix_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    send_pixel(p, 0);
  endtask

  initial begin
    int idle_pct;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_pixel = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Black, white and grays.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(1, 1, 1);
    send_rgb(128, 128, 128);
    // Each channel largest, with ties resolved toward red then green.
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    // Red largest with green below blue wraps the numerator.
    send_rgb(255, 0, 1);
    send_rgb(200, 10, 150);
    send_rgb(10, 200, 150);
    send_rgb(150, 10, 200);
    send_rgb(1, 0, 0);
    send_rgb(255, 254, 254);
    send_rgb(255, 254, 0);
    send_rgb(0, 1, 255);
    send_rgb(170, 85, 0);
    send_rgb(2, 1, 0);

    for (int i = 0; i < 650; i++) begin
      idle_pct = (i < 220) ? 11 : (i < 440) ? 57 : 0;
      send_pixel(rand_pixel(), idle_pct);
    end
    start <= 1'b0;

    while (pending_hsv != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("rgb_to_hsv_converter_unit: match");
    end else begin
      $display("rgb_to_hsv_converter_unit: mismatch");
    end
    $finish;
  end

endmodule
